// ===== hdl/wrb_pkg.sv =====
package wrb_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_HEADER = 3'd0,
        OP_PUSH_DATA   = 3'd1,
        OP_QUERY       = 3'd2,
        OP_FETCH       = 3'd3,
        OP_CLEAR       = 3'd4
    } t_op;

    localparam logic [2:0] KIND_PUSH_ACK = 3'd0;
    localparam logic [2:0] KIND_STATUS   = 3'd1;
    localparam logic [2:0] KIND_HEADER   = 3'd2;
    localparam logic [2:0] KIND_BYTE     = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    localparam logic [1:0] STATUS_SUCCESS  = 2'd0;
    localparam logic [1:0] STATUS_UPTODATE = 2'd1;
    localparam logic [1:0] STATUS_SNAPSHOT = 2'd2;

    localparam int TOTAL_W = 9;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  component;
        logic [7:0]  tag;
        logic [7:0]  value_length;
        logic [7:0]  value_byte;
        logic [31:0] since_sequence;
        logic [31:0] record_limit;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sequence_res;
        logic [7:0]  out_component;
        logic [7:0]  out_tag;
        logic [7:0]  out_value_length;
        logic [7:0]  out_byte;
        logic [1:0]  status;
        logic        last;
        logic [31:0] head_sequence;
        logic [31:0] oldest_sequence;
        logic [8:0]  held_records;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [7:0]         comp;
        logic [7:0]         tag;
        logic [7:0]         vlen;
        logic [7:0]         vbyte;
        logic [31:0]        since;
        logic [31:0]        limit;
        logic [TOTAL_W-1:0] total;
        logic               too_big;
    } t_cmd;

endpackage

// ===== hdl/wrb_front.sv =====
module wrb_front import wrb_pkg::*; #(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    t_cmd       cmd;
    logic       keep, push;

    always_comb begin
        cmd.op      = t_op'(i_in_item.opcode);
        cmd.comp    = i_in_item.component;
        cmd.tag     = i_in_item.tag;
        cmd.vlen    = i_in_item.value_length;
        cmd.vbyte   = i_in_item.value_byte;
        cmd.since   = i_in_item.since_sequence;
        cmd.limit   = i_in_item.record_limit;
        cmd.total   = TOTAL_W'(HEADER_BYTES) + TOTAL_W'(i_in_item.value_length);
        cmd.too_big = 32'(cmd.total) > 32'(RING_BYTES);
    end

    // Undefined opcodes are accepted and dropped here; they cause no result.
    assign keep        = i_in_item.opcode <= OP_CLEAR;
    assign o_in_ready  = r_fill != 2'd2;
    assign push        = i_in_valid && o_in_ready && keep;
    assign o_cmd_valid = r_fill != 2'd0;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(push) - 2'(i_cmd_pop);
        end
    end

endmodule

// ===== hdl/wrb_engine.sv =====
module wrb_engine import wrb_pkg::*; #(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 12,
    parameter int WRAP_MARK    = 65535
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW      = $clog2(RING_BYTES);
    localparam int OW      = $clog2(RING_BYTES + 512) + 1;
    localparam int HW      = $clog2(HEADER_BYTES);
    localparam int CNT_MAX = RING_BYTES / HEADER_BYTES + 1;
    localparam int CW_RAW  = $clog2(CNT_MAX + 1);
    localparam int CW      = (CW_RAW < 9) ? 9 : CW_RAW;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_RD_DATA, S_WHDR, S_PA, S_PA2, S_PB, S_PFIN,
        S_DROP, S_D1, S_D2, S_D3, S_D4, S_SCAN, S_S1, S_S2, S_S3, S_FBYTE, S_EMIT,
        S_CLR
    } t_state;

    t_state r_state, n_state, r_ret, n_ret, r_dret, n_dret, r_wret, n_wret;
    logic [OW-1:0] r_head, n_head, r_tail, n_tail, r_wc, n_wc, r_scur, n_scur;
    logic [OW-1:0] r_slen, n_slen, r_rd_addr, n_rd_addr, r_wr_base, n_wr_base;
    logic [OW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_cnt, n_cnt, r_insp, n_insp;
    logic [31:0]   r_newest, n_newest, r_oldest, n_oldest, r_since, n_since;
    logic [31:0]   r_limit, n_limit, r_emitted, n_emitted;
    logic [7:0]    r_left, n_left;
    logic          r_active, n_active;
    logic [2:0]    r_rd_idx, n_rd_idx, r_rd_n, n_rd_n;
    logic [55:0]   r_acc, n_acc;
    logic [7:0]    r_mem_q;
    logic [HW-1:0] r_wr_idx, n_wr_idx;
    logic [15:0]   r_h_len, n_h_len;
    logic [31:0]   r_h_seq, n_h_seq;
    logic [7:0]    r_h_comp, n_h_comp, r_h_tag, n_h_tag, r_h_vlen, n_h_vlen;
    t_cmd          r_cmd, n_cmd;
    logic [2:0]    r_d_kind, n_d_kind;
    logic [31:0]   r_d_seq, n_d_seq;
    logic [7:0]    r_d_comp, n_d_comp, r_d_tag, n_d_tag, r_d_vlen, n_d_vlen;
    logic [7:0]    r_d_byte, n_d_byte;
    logic [1:0]    r_d_status, n_d_status;
    logic          r_d_last, n_d_last;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic [7:0]    r_mem [0:RING_BYTES-1];
    logic          mem_we;
    logic [OW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [7:0]    hdr_byte;
    logic [15:0]   len;
    logic [OW-1:0] len_ext, total_ext, new_tail;
    logic          len_bad, len_wrap;

    assign len       = r_acc[15:0];
    assign len_ext   = OW'(len);
    assign len_wrap  = len == 16'(WRAP_MARK);
    assign len_bad   = (len < 16'(HEADER_BYTES)) || (32'(len) > 32'(RING_BYTES));
    assign total_ext = OW'(r_cmd.total);
    assign new_tail  = r_tail + len_ext;

    always_comb begin
        case (r_wr_idx)
            HW'(0):  hdr_byte = r_h_len[7:0];
            HW'(1):  hdr_byte = r_h_len[15:8];
            HW'(2):  hdr_byte = r_h_seq[7:0];
            HW'(3):  hdr_byte = r_h_seq[15:8];
            HW'(4):  hdr_byte = r_h_seq[23:16];
            HW'(5):  hdr_byte = r_h_seq[31:24];
            HW'(6):  hdr_byte = r_h_comp;
            HW'(7):  hdr_byte = r_h_tag;
            HW'(8):  hdr_byte = r_h_vlen;
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_dret = r_dret;  n_wret = r_wret;
        n_head = r_head;  n_tail = r_tail;  n_wc = r_wc;  n_scur = r_scur;
        n_slen = r_slen;  n_rd_addr = r_rd_addr;  n_wr_base = r_wr_base;
        n_clr = r_clr;
        n_cnt = r_cnt;  n_insp = r_insp;  n_newest = r_newest;  n_oldest = r_oldest;
        n_since = r_since;  n_limit = r_limit;  n_emitted = r_emitted;
        n_left = r_left;  n_active = r_active;  n_rd_idx = r_rd_idx;  n_rd_n = r_rd_n;
        n_acc = r_acc;  n_wr_idx = r_wr_idx;  n_h_len = r_h_len;  n_h_seq = r_h_seq;
        n_h_comp = r_h_comp;  n_h_tag = r_h_tag;  n_h_vlen = r_h_vlen;  n_cmd = r_cmd;
        n_d_kind = r_d_kind;  n_d_seq = r_d_seq;  n_d_comp = r_d_comp;
        n_d_tag = r_d_tag;  n_d_vlen = r_d_vlen;  n_d_byte = r_d_byte;
        n_d_status = r_d_status;  n_d_last = r_d_last;
        n_out_valid = r_out_valid;  n_out = r_out;
        mem_we = 1'b0;  mem_wa = r_wc;  mem_wd = r_cmd.vbyte;
        o_cmd_pop = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // A command starts only with the output register free, so every
                // result finds room when it is ready.
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_d_kind   = KIND_PUSH_ACK;
                    n_d_seq    = 32'd0;
                    n_d_comp   = 8'd0;
                    n_d_tag    = 8'd0;
                    n_d_vlen   = 8'd0;
                    n_d_byte   = 8'd0;
                    n_d_status = STATUS_SUCCESS;
                    n_d_last   = 1'b0;
                    case (i_cmd.op)
                        OP_PUSH_HEADER: begin
                            if (i_cmd.too_big) begin
                                n_wc    = r_head;
                                n_state = S_EMIT;
                            end else if (r_head + OW'(i_cmd.total) > OW'(RING_BYTES)) begin
                                n_state = S_PA;
                            end else begin
                                n_state = S_PB;
                            end
                        end
                        OP_PUSH_DATA: begin
                            if (r_wc < r_head) begin
                                mem_we = 1'b1;
                                mem_wa = r_wc;
                                mem_wd = i_cmd.vbyte;
                                n_wc   = r_wc + OW'(1);
                            end
                        end
                        OP_QUERY: begin
                            n_d_kind = KIND_STATUS;
                            n_active = 1'b0;
                            n_state  = S_EMIT;
                            if (r_cnt == '0 || i_cmd.since == r_newest) begin
                                n_d_status = STATUS_UPTODATE;
                                n_d_last   = 1'b1;
                            end else if (i_cmd.since > r_newest ||
                                         (i_cmd.since != 32'd0 && i_cmd.since < r_oldest)) begin
                                n_d_status = STATUS_SNAPSHOT;
                                n_d_last   = 1'b1;
                            end else begin
                                n_since   = i_cmd.since;
                                n_limit   = i_cmd.limit;
                                n_scur    = r_tail;
                                n_insp    = '0;
                                n_emitted = 32'd0;
                                n_left    = 8'd0;
                                n_active  = 1'b1;
                            end
                        end
                        OP_FETCH: begin
                            if (!r_active) begin
                                n_d_kind = KIND_END;
                                n_d_last = 1'b1;
                                n_state  = S_EMIT;
                            end else if (r_left != 8'd0) begin
                                n_rd_addr = r_scur - OW'(r_left);
                                n_rd_idx  = 3'd0;
                                n_rd_n    = 3'd1;
                                n_ret     = S_FBYTE;
                                n_state   = S_RD_WAIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_head = '0;  n_tail = '0;  n_wc = '0;  n_scur = '0;
                            n_cnt = '0;  n_insp = '0;  n_newest = 32'd0;
                            n_oldest = 32'd0;  n_since = 32'd0;  n_limit = 32'd0;
                            n_emitted = 32'd0;  n_left = 8'd0;  n_active = 1'b0;
                            n_clr = '0;
                            n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                // Zero the whole ring one byte per cycle.
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = 8'd0;
                if (r_clr == OW'(RING_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + OW'(1);
                end
            end
            S_RD_WAIT: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_acc[{r_rd_idx, 3'b000} +: 8] = r_mem_q;
                if (r_rd_idx + 3'd1 == r_rd_n) begin
                    n_state = r_ret;
                end else begin
                    n_rd_idx  = r_rd_idx + 3'd1;
                    n_rd_addr = r_rd_addr + OW'(1);
                    n_state   = S_RD_WAIT;
                end
            end
            S_WHDR: begin
                mem_we = 1'b1;
                mem_wa = r_wr_base + OW'(r_wr_idx);
                mem_wd = hdr_byte;
                if (r_wr_idx == HW'(HEADER_BYTES - 1)) begin
                    n_state = r_wret;
                end else begin
                    n_wr_idx = r_wr_idx + HW'(1);
                end
            end
            S_PA: begin
                // The record runs past the end: clear out everything at or
                // beyond the head, then mark the wrap and restart at zero.
                if (r_cnt != '0 && r_tail >= r_head) begin
                    n_dret  = S_PA;
                    n_state = S_DROP;
                end else if (r_head + OW'(HEADER_BYTES) <= OW'(RING_BYTES)) begin
                    n_h_len   = 16'(WRAP_MARK);
                    n_h_seq   = 32'd0;
                    n_h_comp  = 8'd0;
                    n_h_tag   = 8'd0;
                    n_h_vlen  = 8'd0;
                    n_wr_base = r_head;
                    n_wr_idx  = '0;
                    n_wret    = S_PA2;
                    n_state   = S_WHDR;
                end else begin
                    n_state = S_PA2;
                end
            end
            S_PA2: begin
                n_head  = '0;
                n_state = S_PB;
            end
            S_PB: begin
                if (r_cnt != '0 && r_head <= r_tail && r_head + total_ext > r_tail) begin
                    n_dret  = S_PB;
                    n_state = S_DROP;
                end else begin
                    n_newest = r_newest + 32'd1;
                    if (r_cnt == '0) begin
                        n_oldest = r_newest + 32'd1;
                        n_tail   = r_head;
                    end
                    n_h_len   = 16'(r_cmd.total);
                    n_h_seq   = r_newest + 32'd1;
                    n_h_comp  = r_cmd.comp;
                    n_h_tag   = r_cmd.tag;
                    n_h_vlen  = r_cmd.vlen;
                    n_wr_base = r_head;
                    n_wr_idx  = '0;
                    n_wret    = S_PFIN;
                    n_state   = S_WHDR;
                end
            end
            S_PFIN: begin
                n_wc    = r_head + OW'(HEADER_BYTES);
                n_head  = r_head + total_ext;
                n_cnt   = r_cnt + CW'(1);
                n_d_seq = r_newest;
                n_state = S_EMIT;
            end
            S_DROP: begin
                if (r_tail + OW'(HEADER_BYTES) > OW'(RING_BYTES)) begin
                    n_tail  = '0;
                    n_state = r_dret;
                end else begin
                    n_rd_addr = r_tail;
                    n_rd_idx  = 3'd0;
                    n_rd_n    = 3'd2;
                    n_ret     = S_D1;
                    n_state   = S_RD_WAIT;
                end
            end
            S_D1: begin
                if (len_wrap) begin
                    n_tail    = '0;
                    n_rd_addr = '0;
                    n_rd_idx  = 3'd0;
                    n_rd_n    = 3'd2;
                    n_ret     = S_D2;
                    n_state   = S_RD_WAIT;
                end else begin
                    n_state = S_D2;
                end
            end
            S_D2: begin
                if (len_bad) begin
                    // A corrupt length leaves nothing trustworthy: empty the ring.
                    n_tail  = r_head;
                    n_cnt   = '0;
                    n_state = r_dret;
                end else begin
                    n_tail = new_tail;
                    n_cnt  = r_cnt - CW'(1);
                    if (new_tail + OW'(HEADER_BYTES) <= OW'(RING_BYTES)) begin
                        n_rd_addr = new_tail;
                        n_rd_idx  = 3'd0;
                        n_rd_n    = 3'd2;
                        n_ret     = S_D3;
                        n_state   = S_RD_WAIT;
                    end else begin
                        n_tail = '0;
                        if (r_cnt > CW'(1)) begin
                            n_rd_addr = OW'(2);
                            n_rd_idx  = 3'd0;
                            n_rd_n    = 3'd4;
                            n_ret     = S_D4;
                            n_state   = S_RD_WAIT;
                        end else begin
                            n_state = r_dret;
                        end
                    end
                end
            end
            S_D3: begin
                if (len_wrap) begin
                    n_tail = '0;
                end
                if (r_cnt != '0) begin
                    n_rd_addr = len_wrap ? OW'(2) : r_tail + OW'(2);
                    n_rd_idx  = 3'd0;
                    n_rd_n    = 3'd4;
                    n_ret     = S_D4;
                    n_state   = S_RD_WAIT;
                end else begin
                    n_state = r_dret;
                end
            end
            S_D4: begin
                n_oldest = r_acc[31:0];
                n_state  = r_dret;
            end
            S_SCAN: begin
                if (r_insp < r_cnt && r_emitted < r_limit) begin
                    if (r_scur + OW'(HEADER_BYTES) > OW'(RING_BYTES)) begin
                        n_scur = '0;
                    end else begin
                        n_rd_addr = r_scur;
                        n_rd_idx  = 3'd0;
                        n_rd_n    = 3'd2;
                        n_ret     = S_S1;
                        n_state   = S_RD_WAIT;
                    end
                end else begin
                    n_active = 1'b0;
                    n_d_kind = KIND_END;
                    n_d_last = 1'b1;
                    n_state  = S_EMIT;
                end
            end
            S_S1: begin
                if (len_wrap) begin
                    n_scur    = '0;
                    n_rd_addr = '0;
                    n_rd_idx  = 3'd0;
                    n_rd_n    = 3'd2;
                    n_ret     = S_S2;
                    n_state   = S_RD_WAIT;
                end else begin
                    n_state = S_S2;
                end
            end
            S_S2: begin
                if (len_bad) begin
                    n_active = 1'b0;
                    n_d_kind = KIND_END;
                    n_d_last = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    // Sequence, component, tag and value length in one burst.
                    n_slen    = len_ext;
                    n_rd_addr = r_scur + OW'(2);
                    n_rd_idx  = 3'd0;
                    n_rd_n    = 3'd7;
                    n_ret     = S_S3;
                    n_state   = S_RD_WAIT;
                end
            end
            S_S3: begin
                n_scur = r_scur + r_slen;
                n_insp = r_insp + CW'(1);
                if (r_acc[31:0] > r_since) begin
                    n_d_kind  = KIND_HEADER;
                    n_d_seq   = r_acc[31:0];
                    n_d_comp  = r_acc[39:32];
                    n_d_tag   = r_acc[47:40];
                    n_d_vlen  = r_acc[55:48];
                    n_left    = r_acc[55:48];
                    n_emitted = r_emitted + 32'd1;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_FBYTE: begin
                n_d_kind = KIND_BYTE;
                n_d_byte = r_acc[7:0];
                n_left   = r_left - 8'd1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_out_valid           = 1'b1;
                n_out.kind            = r_d_kind;
                n_out.sequence_res    = r_d_seq;
                n_out.out_component   = r_d_comp;
                n_out.out_tag         = r_d_tag;
                n_out.out_value_length = r_d_vlen;
                n_out.out_byte        = r_d_byte;
                n_out.status          = r_d_status;
                n_out.last            = r_d_last;
                n_out.head_sequence   = r_newest;
                n_out.oldest_sequence = r_oldest;
                n_out.held_records    = r_cnt[8:0];
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[AW-1:0]] <= mem_wd;
        end
        r_mem_q <= r_mem[r_rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_dret <= n_dret;  r_wret <= n_wret;
        r_slen <= n_slen;  r_rd_addr <= n_rd_addr;  r_wr_base <= n_wr_base;
        r_clr <= n_clr;
        r_since <= n_since;  r_limit <= n_limit;
        r_rd_idx <= n_rd_idx;  r_rd_n <= n_rd_n;  r_acc <= n_acc;  r_wr_idx <= n_wr_idx;
        r_h_len <= n_h_len;  r_h_seq <= n_h_seq;  r_h_comp <= n_h_comp;
        r_h_tag <= n_h_tag;  r_h_vlen <= n_h_vlen;  r_cmd <= n_cmd;
        r_d_kind <= n_d_kind;  r_d_seq <= n_d_seq;  r_d_comp <= n_d_comp;
        r_d_tag <= n_d_tag;  r_d_vlen <= n_d_vlen;  r_d_byte <= n_d_byte;
        r_d_status <= n_d_status;  r_d_last <= n_d_last;  r_out <= n_out;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;  r_tail <= '0;  r_wc <= '0;  r_scur <= '0;
            r_cnt <= '0;  r_insp <= '0;  r_newest <= 32'd0;  r_oldest <= 32'd0;
            r_emitted <= 32'd0;  r_left <= 8'd0;  r_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;  r_tail <= n_tail;  r_wc <= n_wc;  r_scur <= n_scur;
            r_cnt <= n_cnt;  r_insp <= n_insp;  r_newest <= n_newest;
            r_oldest <= n_oldest;  r_emitted <= n_emitted;  r_left <= n_left;
            r_active <= n_active;  r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_head_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= OW'(RING_BYTES))
        else $error("head offset beyond the ring");
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_out_valid)
        else $error("result produced while the output register is full");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE && i_cmd_valid))
        else $error("command popped outside idle");
    a_read_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_DATA) |-> (r_rd_idx < r_rd_n))
        else $error("read burst index overran its length");
`endif

endmodule

// ===== hdl/wal_record_ring_buffer.sv =====
// Byte ring of log records with overwrite of the oldest record. Items enter a
// two-entry command queue and are carried out one at a time by a sequencer on
// a byte memory with one write port and one registered read port; each byte
// read passes through a wait state and a data state. The ring memory is not
// cleared by reset; send a clear item first, which zeroes it one byte per cycle.
// Results wait in an output register while further items are queued.
module wal_record_ring_buffer import wrb_pkg::*; #(
    parameter int RING_BYTES   = 4096,
    parameter int HEADER_BYTES = 12,
    parameter int WRAP_MARK    = 65535
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    wrb_front #(
        .RING_BYTES  (RING_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    wrb_engine #(
        .RING_BYTES  (RING_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .WRAP_MARK   (WRAP_MARK)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

// ===== verif/wrb_ring_checker.sv =====
`timescale 1ns / 100ps

module wrb_ring_checker import wrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    output int          o_errors,
    output int          o_pending,
    output logic [31:0] o_newest,
    output logic [31:0] o_oldest,
    output int          o_items_in,
    output int          o_results,
    output int          o_wraps,
    output int          o_headers
);

    localparam int unsigned RB = 4096;
    localparam int unsigned HB = 12;
    localparam int unsigned WM = 65535;

    // Shadow copy of the ring and its pointers.
    logic [7:0]  mem [RB];
    int unsigned head_off, tail_off, n_rec, wcur;
    logic [31:0] newest, oldest;
    int unsigned scur, s_insp, s_left;
    logic [31:0] s_emit, q_since, q_limit;
    bit          s_on;

    t_out_item   pending_replies [$];
    int          errors, items_in, results, wraps, headers;

    assign o_errors   = errors;
    assign o_pending  = pending_replies.size();
    assign o_newest   = newest;
    assign o_oldest   = oldest;
    assign o_items_in = items_in;
    assign o_results  = results;
    assign o_wraps    = wraps;
    assign o_headers  = headers;

    function automatic int unsigned rd(int unsigned a);
        return mem[a % RB];
    endfunction

    function automatic int unsigned rd_len(int unsigned a);
        return rd(a) | (rd(a + 1) << 8);
    endfunction

    function automatic logic [31:0] rd_seq(int unsigned a);
        return 32'(rd(a + 2) | (rd(a + 3) << 8) | (rd(a + 4) << 16) | (rd(a + 5) << 24));
    endfunction

    function automatic void wr(int unsigned a, logic [7:0] v);
        mem[a % RB] = v;
    endfunction

    function automatic void wr_hdr(int unsigned a, int unsigned len, logic [31:0] seq,
                                   logic [7:0] comp, logic [7:0] tag, logic [7:0] vlen);
        wr(a, len[7:0]);
        wr(a + 1, len[15:8]);
        for (int i = 0; i < 4; i++) wr(a + 2 + i, seq[8*i +: 8]);
        wr(a + 6, comp);
        wr(a + 7, tag);
        wr(a + 8, vlen);
        for (int unsigned i = 9; i < HB; i++) wr(a + i, 8'h00);
    endfunction

    function automatic void ring_wipe();
        foreach (mem[i]) mem[i] = 8'h00;
        head_off = 0; tail_off = 0; n_rec = 0; wcur = 0;
        newest = 0; oldest = 0;
        scur = 0; s_insp = 0; s_emit = 0; s_left = 0;
        q_since = 0; q_limit = 0; s_on = 0;
    endfunction

    function automatic void ring_drop_oldest();
        int unsigned len;
        if (n_rec == 0) return;
        if (tail_off + HB > RB) begin
            tail_off = 0;
            return;
        end
        len = rd_len(tail_off);
        if (len == WM) begin
            tail_off = 0;
            len = rd_len(0);
        end
        // A broken length makes the rest of the ring unreadable, so it is dropped.
        if (len < HB || len > RB) begin
            tail_off = head_off;
            n_rec = 0;
            return;
        end
        tail_off += len;
        n_rec--;
        if (tail_off + HB <= RB && rd_len(tail_off) != WM) begin
            if (n_rec > 0) oldest = rd_seq(tail_off);
        end else begin
            tail_off = 0;
            if (n_rec > 0) oldest = rd_seq(0);
        end
    endfunction

    function automatic logic [31:0] ring_push(logic [7:0] comp, logic [7:0] tag,
                                              logic [7:0] vlen);
        int unsigned total;
        total = HB + vlen;
        if (total > RB) begin
            wcur = head_off;
            return 32'd0;
        end
        if (head_off + total > RB) begin
            while (n_rec > 0 && tail_off >= head_off) ring_drop_oldest();
            if (head_off + HB <= RB) wr_hdr(head_off, WM, 32'd0, 8'd0, 8'd0, 8'd0);
            head_off = 0;
            wraps++;
        end
        while (n_rec > 0 && head_off <= tail_off && head_off + total > tail_off)
            ring_drop_oldest();
        newest++;
        if (n_rec == 0) begin
            oldest = newest;
            tail_off = head_off;
        end
        wr_hdr(head_off, total, newest, comp, tag, vlen);
        wcur = head_off + HB;
        head_off += total;
        n_rec++;
        return newest;
    endfunction

    function automatic void ring_fetch(inout t_out_item r);
        int unsigned len;
        logic [31:0] seq;
        if (!s_on) begin
            r.kind = KIND_END;
            r.last = 1'b1;
            return;
        end
        if (s_left > 0) begin
            r.kind = KIND_BYTE;
            r.out_byte = rd(scur + RB - s_left);
            s_left--;
            return;
        end
        while (s_insp < n_rec && s_emit < q_limit) begin
            if (scur + HB > RB) scur = 0;
            len = rd_len(scur);
            if (len == WM) begin
                scur = 0;
                len = rd_len(0);
            end
            if (len < HB || len > RB) break;
            seq = rd_seq(scur);
            if (seq > q_since) begin
                r.kind = KIND_HEADER;
                r.sequence_res = seq;
                r.out_component = rd(scur + 6);
                r.out_tag = rd(scur + 7);
                r.out_value_length = rd(scur + 8);
                s_left = r.out_value_length;
                scur += len;
                s_insp++;
                s_emit++;
                return;
            end
            scur += len;
            s_insp++;
        end
        s_on = 0;
        r.kind = KIND_END;
        r.last = 1'b1;
    endfunction

    function automatic bit ring_step(t_in_item it, output t_out_item r);
        r = '0;
        case (it.opcode)
            OP_PUSH_HEADER: begin
                r.kind = KIND_PUSH_ACK;
                r.sequence_res = ring_push(it.component, it.tag, it.value_length);
            end
            OP_PUSH_DATA: begin
                if (wcur < head_off) begin
                    wr(wcur, it.value_byte);
                    wcur++;
                end
                return 0;
            end
            OP_QUERY: begin
                r.kind = KIND_STATUS;
                s_on = 0;
                if (n_rec == 0 || it.since_sequence == newest) begin
                    r.status = STATUS_UPTODATE;
                    r.last = 1'b1;
                end else if (it.since_sequence > newest ||
                             (it.since_sequence > 0 && it.since_sequence < oldest)) begin
                    r.status = STATUS_SNAPSHOT;
                    r.last = 1'b1;
                end else begin
                    r.status = STATUS_SUCCESS;
                    q_since = it.since_sequence;
                    q_limit = it.record_limit;
                    scur = tail_off;
                    s_insp = 0;
                    s_emit = 0;
                    s_left = 0;
                    s_on = 1;
                end
            end
            OP_FETCH: ring_fetch(r);
            OP_CLEAR: begin
                ring_wipe();
                return 0;
            end
            default: return 0;
        endcase
        r.head_sequence = newest;
        r.oldest_sequence = oldest;
        r.held_records = n_rec[8:0];
        return 1;
    endfunction

    function automatic void cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item r;
        if (!i_rst_n) begin
            ring_wipe();
            pending_replies.delete();
        end else begin
            // Results leaving now were caused by earlier items, so check them first.
            if (i_out_valid && i_out_ready) begin
                results++;
                if (pending_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, i_out_item);
                end else begin
                    e = pending_replies.pop_front();
                    if (e.kind == KIND_HEADER) headers++;
                    cmp("kind", e.kind, i_out_item.kind);
                    cmp("sequence_res", e.sequence_res, i_out_item.sequence_res);
                    cmp("out_component", e.out_component, i_out_item.out_component);
                    cmp("out_tag", e.out_tag, i_out_item.out_tag);
                    cmp("out_value_length", e.out_value_length,
                        i_out_item.out_value_length);
                    cmp("out_byte", e.out_byte, i_out_item.out_byte);
                    cmp("status", e.status, i_out_item.status);
                    cmp("last", e.last, i_out_item.last);
                    cmp("head_sequence", e.head_sequence, i_out_item.head_sequence);
                    cmp("oldest_sequence", e.oldest_sequence, i_out_item.oldest_sequence);
                    cmp("held_records", e.held_records, i_out_item.held_records);
                end
            end
            if (i_in_valid && i_in_ready) begin
                items_in++;
                if (ring_step(i_in_item, r)) pending_replies = {pending_replies, r};
            end
        end
    end

endmodule

// ===== verif/tb_wal_record_ring_buffer.sv =====
`timescale 1ns / 100ps

module tb_wal_record_ring_buffer;
    import wrb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;

    int          errors, pending, items_in, results, wraps, headers;
    logic [31:0] newest, oldest;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          sent = 0;

    always #10 i_clk = ~i_clk;

    wal_record_ring_buffer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    wrb_ring_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_newest    (newest),
        .o_oldest    (oldest),
        .o_items_in  (items_in),
        .o_results   (results),
        .o_wraps     (wraps),
        .o_headers   (headers)
    );

    always @(posedge i_clk) out_ready <= ($urandom_range(99) >= stall_pct);

    function automatic t_in_item mk(t_op op);
        t_in_item it;
        it.opcode = op;
        it.component = 8'($urandom);
        it.tag = 8'($urandom);
        it.value_length = 8'($urandom);
        it.value_byte = 8'($urandom);
        it.since_sequence = $urandom;
        it.record_limit = $urandom;
        return it;
    endfunction

    task automatic send(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge i_clk iff in_ready);
        sent++;
    endtask

    // Header followed by ndata of its value bytes; any bytes not sent keep old contents.
    task automatic push_head(logic [7:0] vlen, int ndata);
        t_in_item it;
        it = mk(OP_PUSH_HEADER);
        it.value_length = vlen;
        send(it);
        repeat (ndata) send(mk(OP_PUSH_DATA));
    endtask

    task automatic push(logic [7:0] vlen);
        push_head(vlen, int'(vlen));
    endtask

    task automatic query(logic [31:0] since, logic [31:0] lim);
        t_in_item it;
        it = mk(OP_QUERY);
        it.since_sequence = since;
        it.record_limit = lim;
        send(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // A push data or clear item has no result but may still be in flight.
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_since();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return newest;
            2: return newest - $urandom_range(1, 5);
            3: return oldest - 1;
            4: return oldest - $urandom_range(2, 4);
            5: return newest + 1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(4))
            0: return 32'd0;
            1, 2: return $urandom_range(1, 6);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_sequence();
        int sel;
        t_in_item it;
        sel = $urandom_range(99);
        if (sel < 35) begin
            case ($urandom_range(49))
                0: push(8'($urandom_range(5, 40)));
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                16, 17, 18, 19, 20, 21, 22: push(8'($urandom_range(1, 4)));
                default: push(8'd0);
            endcase
            // An extra data item past the end of the record is dropped.
            if ($urandom_range(9) == 0) send(mk(OP_PUSH_DATA));
        end else if (sel < 60) begin
            // Records with no data items, many of them long, fill the ring and force wraps.
            repeat ($urandom_range(10, 30)) begin
                if ($urandom_range(1) == 0) begin
                    push(8'd0);
                end else begin
                    push_head(8'($urandom_range(64, 255)), 0);
                end
            end
        end else if (sel < 88) begin
            query(pick_since(), pick_limit());
            repeat ($urandom_range(1, 15)) begin
                if ($urandom_range(9) == 0) push(8'($urandom_range(0, 3)));
                send(mk(OP_FETCH));
            end
        end else if (sel < 95) begin
            send(mk(OP_FETCH));
        end else if (sel < 97) begin
            it = mk(OP_CLEAR);
            it.opcode = OP_CLEAR + 3'($urandom_range(1, 3));
            send(it);
        end else if (sel < 98) begin
            send(mk(OP_CLEAR));
        end else begin
            drain();
        end
    endtask

    initial begin
        t_in_item it;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The ring memory is undefined after reset until a clear zeroes it.
        send(mk(OP_CLEAR));

        // Directed: empty ring, the field extremes, each status and the scan end.
        send(mk(OP_FETCH));
        query(32'd0, 32'hFFFF_FFFF);
        it = mk(OP_PUSH_HEADER);
        it.component = 8'hFF;
        it.tag = 8'h00;
        it.value_length = 8'd0;
        send(it);
        it = mk(OP_PUSH_HEADER);
        it.component = 8'h00;
        it.tag = 8'hFF;
        it.value_length = 8'd3;
        send(it);
        it = mk(OP_PUSH_DATA);
        it.value_byte = 8'h00;
        send(it);
        it.value_byte = 8'hFF;
        send(it);
        it.value_byte = 8'hA5;
        send(it);
        send(mk(OP_PUSH_DATA));
        push(8'd1);
        query(32'd0, 32'hFFFF_FFFF);
        repeat (7) send(mk(OP_FETCH));
        query(32'd3, $urandom);
        query(32'hFFFF_FFFF, $urandom);
        query(32'd1, 32'd0);
        send(mk(OP_FETCH));
        send(mk(OP_CLEAR));
        it = mk(OP_CLEAR);
        it.opcode = OP_CLEAR + 3'd3;
        send(it);
        query(32'd0, 32'hFFFF_FFFF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            sent = 0;
            if (ph == 0) push_head(8'd255, 8);
            while (sent < 110) random_sequence();
            drain();
        end

        stall_pct = 0;
        repeat (100) @(posedge i_clk);
        $display("Run covered %0d items in and %0d results out, %0d fetched headers,",
                 items_in, results, headers);
        $display("%0d ring wraps, across four handshake pressure phases.", wraps);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #500ms;
        $display("Timeout with %0d results still expected.", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/wrb_pkg.sv
hdl/wrb_front.sv
hdl/wrb_engine.sv
hdl/wal_record_ring_buffer.sv
verif/wrb_ring_checker.sv
verif/tb_wal_record_ring_buffer.sv
